@@ rtl/fmi_pkg.sv @@
// ----------------------------------------------------------------------------
// fmi_pkg
// Constants for the modular inverse pipeline over the prime 998244353.
// ----------------------------------------------------------------------------
package fmi_pkg;

    localparam int unsigned RES_W = 30;

    localparam logic [RES_W-1:0] PRIME = 30'd998244353;
    localparam logic [63:0]      PRIME_64 = 64'd998244353;

    // exponent P-2; bits above 29 are zero
    localparam logic [63:0] EXPONENT = PRIME_64 - 64'd2;

    // Barrett constant floor(2^60 / P), fits in 31 bits
    localparam logic [30:0] BARRETT_M = 31'((64'd1 << 60) / PRIME_64);

    typedef logic [RES_W-1:0] t_res;

endpackage

@@ rtl/fmi_mulmod.sv @@
// ----------------------------------------------------------------------------
// fmi_mulmod
// Four-stage a*b mod P: product, Barrett quotient, remainder, final correction.
// ----------------------------------------------------------------------------
module fmi_mulmod (
    input  logic           i_clk,
    input  logic           i_en,
    input  fmi_pkg::t_res  i_a,
    input  fmi_pkg::t_res  i_b,
    output fmi_pkg::t_res  o_res
);

    logic [59:0] r_prod;
    logic [61:0] r_qraw;
    logic [31:0] r_xlo;
    logic [31:0] r_rem;
    fmi_pkg::t_res r_res;

    logic [60:0] n_qp;
    logic [31:0] n_rem;
    logic [31:0] w_p2;
    logic [31:0] w_p1;
    fmi_pkg::t_res n_res;

    assign w_p1 = {2'b00, fmi_pkg::PRIME};
    assign w_p2 = {1'b0, fmi_pkg::PRIME, 1'b0};

    always_comb begin
        n_qp  = 61'(r_qraw[61:31]) * 61'(fmi_pkg::PRIME);
        // true remainder is below 3P < 2^32, so low bits suffice
        n_rem = r_xlo - n_qp[31:0];
        if (r_rem >= w_p2) begin
            n_res = fmi_pkg::t_res'(r_rem - w_p2);
        end else if (r_rem >= w_p1) begin
            n_res = fmi_pkg::t_res'(r_rem - w_p1);
        end else begin
            n_res = r_rem[29:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= 60'(i_a) * 60'(i_b);
            r_qraw <= 62'(r_prod[59:29]) * 62'(fmi_pkg::BARRETT_M);
            r_xlo  <= r_prod[31:0];
            r_rem  <= n_rem;
            r_res  <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

@@ rtl/fmi_round.sv @@
// ----------------------------------------------------------------------------
// fmi_round
// One square-and-multiply step: acc*(bit ? sq : 1) and sq*sq, valid tracked.
// ----------------------------------------------------------------------------
module fmi_round (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_use_sq,
    input  logic           i_valid,
    input  fmi_pkg::t_res  i_acc,
    input  fmi_pkg::t_res  i_sq,
    output logic           o_valid,
    output fmi_pkg::t_res  o_acc,
    output fmi_pkg::t_res  o_sq
);

    logic [3:0] r_vld;
    fmi_pkg::t_res w_mul;

    // multiplying by one leaves acc as it is when the exponent bit is clear
    assign w_mul = i_use_sq ? i_sq : fmi_pkg::t_res'(1);

    fmi_mulmod u_acc (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (i_acc),
        .i_b   (w_mul),
        .o_res (o_acc)
    );

    fmi_mulmod u_sq (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (i_sq),
        .i_b   (i_sq),
        .o_res (o_sq)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    assign o_valid = r_vld[3];

endmodule

@@ rtl/fermat_modular_inverse_top.sv @@
// Input register reduces mod P; each exponent bit is a four-stage mulmod round.
// Throughput: one beat per cycle while no output beat is stalled.
// The whole pipeline holds while an output beat waits under stall.
// Reset (synchronous, active low) clears all valid bits; data is not reset.
// ----------------------------------------------------------------------------
// fermat_modular_inverse_top
// Modular inverse mod 998244353 by pipelined right-to-left exponentiation.
// ----------------------------------------------------------------------------
module fermat_modular_inverse_top #(
    parameter int unsigned EXP_BITS = 30
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [29:0] i_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [29:0] o_inverse
);

    logic w_en;
    logic r_v_vld;
    fmi_pkg::t_res r_v;

    logic          w_vld [EXP_BITS+1];
    fmi_pkg::t_res w_acc [EXP_BITS+1];
    fmi_pkg::t_res w_sq  [EXP_BITS+1];

    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_vld <= 1'b0;
        end else if (w_en) begin
            r_v_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_v <= (i_value >= fmi_pkg::PRIME) ? i_value - fmi_pkg::PRIME : i_value;
        end
    end

    assign w_vld[0] = r_v_vld;
    assign w_acc[0] = fmi_pkg::t_res'(1);
    assign w_sq[0]  = r_v;

    for (genvar g = 0; g < EXP_BITS; g++) begin : g_round
        localparam logic USE_SQ = (g < 64) ? fmi_pkg::EXPONENT[g % 64] : 1'b0;
        fmi_round u_round (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_en),
            .i_use_sq (USE_SQ),
            .i_valid  (w_vld[g]),
            .i_acc    (w_acc[g]),
            .i_sq     (w_sq[g]),
            .o_valid  (w_vld[g+1]),
            .o_acc    (w_acc[g+1]),
            .o_sq     (w_sq[g+1])
        );
    end

    assign o_valid   = w_vld[EXP_BITS];
    assign o_inverse = w_acc[EXP_BITS];

endmodule

@@ dv/fermat_modular_inverse_top_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fermat_modular_inverse_top_test
// Drives residues into the modular inverse pipeline with random gaps and
// output stalls, predicts each inverse by square-and-multiply, and compares.
// ----------------------------------------------------------------------------
module fermat_modular_inverse_top_test;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [29:0] i_value = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [29:0] o_inverse;

    // expected inverses in send order
    fmi_pkg::t_res exp_mem [4096];
    logic [11:0]   wr_ptr = '0;
    logic [11:0]   rd_ptr = '0;
    int   n_sent = 0;
    int   n_checked = 0;
    int   n_errors = 0;

    fermat_modular_inverse_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_value(i_value), .o_valid(o_valid), .i_stall(i_stall),
        .o_inverse(o_inverse)
    );

    always #6 i_clk = ~i_clk;

    function automatic fmi_pkg::t_res fermat_inverse(input logic [29:0] v);
        logic [63:0] base;
        logic [63:0] acc;
        logic [63:0] e;
        base = {34'd0, v};
        if (base >= fmi_pkg::PRIME_64) base = base - fmi_pkg::PRIME_64;
        acc = 64'd1;
        e = fmi_pkg::PRIME_64 - 64'd2;
        for (int i = 0; i < 30; i++) begin
            if (e[i]) acc = (acc * base) % fmi_pkg::PRIME_64;
            base = (base * base) % fmi_pkg::PRIME_64;
        end
        return acc[29:0];
    endfunction

    // i_valid stays high after the beat; the caller drops it when done
    task automatic send_residue(input logic [29:0] v, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= v;
        exp_mem[wr_ptr] = fermat_inverse(v);
        wr_ptr = wr_ptr + 12'd1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        n_sent++;
        @(negedge i_clk);
    endtask

    // output stall: per-beat random wait, sometimes none
    initial begin
        int w;
        forever begin
            @(negedge i_clk);
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
            if (w != 0) begin
                i_stall <= 1'b1;
                repeat (w) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (rd_ptr == wr_ptr) begin
                $error("unexpected beat: inverse %0d", o_inverse);
                n_errors++;
            end else begin
                fmi_pkg::t_res exp_inv;
                exp_inv = exp_mem[rd_ptr];
                rd_ptr = rd_ptr + 12'd1;
                if (o_inverse !== exp_inv) begin
                    $error("inverse: expected %0d, got %0d", exp_inv, o_inverse);
                    n_errors++;
                end
                n_checked++;
            end
        end
    end

    task automatic test_edges();
        logic [29:0] list[$];
        list = '{30'd0, 30'd1, 30'd2, 30'd3, fmi_pkg::PRIME - 30'd1,
                 fmi_pkg::PRIME - 30'd2, fmi_pkg::PRIME, fmi_pkg::PRIME + 30'd1,
                 30'h3FFF_FFFF, 30'h2AAA_AAAA, 30'h1555_5555,
                 30'h2000_0000, 30'h1FFF_FFFF, 30'd499122177};
        foreach (list[i]) send_residue(list[i], 1'b0);
    endtask

    task automatic test_random();
        logic [29:0] v;
        for (int i = 0; i < 1600; i++) begin
            case ($urandom_range(0, 9))
                0:       v = 30'($urandom_range(0, 15));
                1:       v = 30'($urandom());
                default: v = 30'($urandom_range(0, 998244352));
            endcase
            send_residue(v, 1'b0);
        end
    endtask

    task automatic test_burst();
        // back-to-back beats without gaps
        for (int i = 0; i < 100; i++) begin
            send_residue(30'($urandom()), 1'b1);
        end
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_edges();
        test_random();
        test_burst();
        i_valid <= 1'b0;
        while (rd_ptr != wr_ptr) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("Sent %0d residues (edges, random, back-to-back), checked %0d inverses.",
                 n_sent, n_checked);
        if (n_errors == 0 && rd_ptr == wr_ptr)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end
endmodule
